/* rtl/core/dpc_pkg.sv */
package dpc_pkg;

    // Widths of the pixel depth and of one colour channel.
    localparam int DEPTH_BITS = 32;
    localparam int COLOR_BITS = 12;

    // Palette layout: segments in use and the size of the constant tables.
    localparam int PALETTE_SEGMENTS = 5;
    localparam int MAX_SEGS = 8;
    localparam int SEG_W = $clog2(MAX_SEGS);
    localparam int COL_IDX_W = $clog2(MAX_SEGS + 1);

    // Q0.16 unit values; UNIT_W holds 0 up to and including 1.0.
    localparam int FRAC_BITS = 16;
    localparam int UNIT_W = FRAC_BITS + 1;
    localparam logic [UNIT_W-1:0] ONE_Q16 = {1'b1, {FRAC_BITS{1'b0}}};

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = DEPTH_BITS;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RANGE_LOW  = 3'd0,
        CFG_RANGE_HIGH = 3'd1,
        CFG_COLOR_MODE = 3'd2,
        CFG_BG_RED     = 3'd3,
        CFG_BG_GREEN   = 3'd4,
        CFG_BG_BLUE    = 3'd5
    } cfg_reg_t;

    // Upper edge of each palette segment, Q0.16.
    localparam logic [UNIT_W-1:0] SEG_EDGE [MAX_SEGS] = '{
        17'd13107, 17'd28180, 17'd43909, 17'd56361,
        17'd65536, 17'd65536, 17'd65536, 17'd65536
    };

    // Palette colours (red, green, blue), Q0.16. Segment i blends entry i into i+1.
    localparam logic [FRAC_BITS-1:0] PAL_COLOR [MAX_SEGS+1][3] = '{
        '{16'd3277,  16'd2621,  16'd9830},
        '{16'd3932,  16'd12780, 16'd32768},
        '{16'd0,     16'd32768, 16'd42598},
        '{16'd23593, 16'd48169, 16'd26870},
        '{16'd63242, 16'd53740, 16'd19661},
        '{16'd64553, 16'd28180, 16'd8192},
        '{16'd64553, 16'd28180, 16'd8192},
        '{16'd64553, 16'd28180, 16'd8192},
        '{16'd64553, 16'd28180, 16'd8192}
    };

    // Flags that travel with a pixel through the depth division.
    typedef struct packed {
        logic bg;
        logic lo_sat;
        logic hi_sat;
    } depth_flags_t;

    // Segment information that travels with a pixel through the blend division.
    typedef struct packed {
        logic              bg;
        logic [UNIT_W-1:0] near;
        logic [SEG_W-1:0]  seg;
        logic              full;
        logic              degen;
    } seg_info_t;

    // Lower edge of a segment: zero for the first, else the previous upper edge.
    function automatic logic [UNIT_W-1:0] seg_lower(input logic [SEG_W-1:0] seg);
        logic [UNIT_W-1:0] low;
        low = '0;
        if (seg != '0)
        begin
            low = SEG_EDGE[SEG_W'(seg - 1'b1)];
        end
        return low;
    endfunction

endpackage

/* rtl/core/depth_palette_colorizer.sv */
// Throughput: one pixel per cycle while the output is not held by color_stall; the two
// 16-step restoring dividers (depth normalization and smoothstep position) are fully
// pipelined, one quotient bit per stage.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads the range,
// mode and background registers with their reset values; no memory needs clearing.
module depth_palette_colorizer
    import dpc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   depth_valid,
    output logic                   depth_stall,
    input  logic [DEPTH_BITS-1:0]  depth_sample,
    input  logic                   sample_finite,
    output logic                   color_valid,
    input  logic                   color_stall,
    output logic [COLOR_BITS-1:0]  red,
    output logic [COLOR_BITS-1:0]  green,
    output logic [COLOR_BITS-1:0]  blue,
    output logic                   is_background,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Stage map. Every stage is one register rank with its own valid bit.
    localparam int DIV_STEPS = FRAC_BITS;
    localparam int ST_IN     = 0;
    localparam int ST_DA0    = ST_IN + 1;
    localparam int ST_NEAR   = ST_DA0 + DIV_STEPS;
    localparam int ST_SEG    = ST_NEAR + 1;
    localparam int ST_DB0    = ST_SEG + 1;
    localparam int ST_U      = ST_DB0 + DIV_STEPS;
    localparam int ST_U2     = ST_U + 1;
    localparam int ST_S      = ST_U2 + 1;
    localparam int ST_P      = ST_S + 1;
    localparam int ST_V      = ST_P + 1;
    localparam int ST_OUT    = ST_V + 1;
    localparam int NSTG      = ST_OUT + 1;

    // Smoothstep product and blend widths.
    localparam int P_W   = (FRAC_BITS + 1) + (UNIT_W + 1);
    localparam int MIX_W = P_W + 2;
    localparam logic [UNIT_W:0] SMOOTH_K = {2'b11, {FRAC_BITS{1'b0}}};
    localparam logic signed [MIX_W-1:0] MIX_ROUND = MIX_W'(1) <<< (FRAC_BITS - 1);
    localparam logic [UNIT_W+COLOR_BITS:0] CH_ROUND =
        (UNIT_W + COLOR_BITS + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [COLOR_BITS-1:0] COLOR_MAX = '1;

    // ------------------------------------------------------------------
    // Configuration registers. The port never pushes back. Software must write only
    // while the pipeline is empty (not enforced here), so the stages read them directly.
    // ------------------------------------------------------------------
    logic [DEPTH_BITS-1:0] range_low_reg;
    logic [DEPTH_BITS-1:0] range_high_reg;
    logic                  color_mode_reg;
    logic [COLOR_BITS-1:0] bg_red_reg;
    logic [COLOR_BITS-1:0] bg_green_reg;
    logic [COLOR_BITS-1:0] bg_blue_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= '0;
            range_high_reg <= DEPTH_BITS'(ONE_Q16);
            color_mode_reg <= 1'b0;
            bg_red_reg     <= '0;
            bg_green_reg   <= '0;
            bg_blue_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_RANGE_LOW:  range_low_reg  <= cfg_data[DEPTH_BITS-1:0];
                CFG_RANGE_HIGH: range_high_reg <= cfg_data[DEPTH_BITS-1:0];
                CFG_COLOR_MODE: color_mode_reg <= cfg_data[0];
                CFG_BG_RED:     bg_red_reg     <= cfg_data[COLOR_BITS-1:0];
                CFG_BG_GREEN:   bg_green_reg   <= cfg_data[COLOR_BITS-1:0];
                CFG_BG_BLUE:    bg_blue_reg    <= cfg_data[COLOR_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. A stage loads when it is empty or when the stage after
    // it loads too, so bubbles close up and a new request is taken even
    // while the output register holds a result that is not yet taken.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] load;
    logic [NSTG-1:0] vld_prev;

    always_comb
    begin
        load[NSTG-1] = !vld_reg[NSTG-1] || !color_stall;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            load[k] = !vld_reg[k] || load[k+1];
        end
    end

    assign vld_prev    = {vld_reg[NSTG-2:0], depth_valid};
    assign depth_stall = !load[ST_IN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= (load & vld_prev) | (~load & vld_reg);
        end
    end

    // ------------------------------------------------------------------
    // Input stage: validity, saturation against the range, and the
    // numerator of the normalization.
    // ------------------------------------------------------------------
    depth_flags_t          in_flags;
    depth_flags_t          s0_flags_reg;
    logic [DEPTH_BITS-1:0] s0_num_reg;
    logic [DEPTH_BITS-1:0] span;

    assign span = range_high_reg - range_low_reg;

    always_comb
    begin
        in_flags.bg     = !sample_finite || (depth_sample == '0) ||
                          (range_high_reg <= range_low_reg);
        in_flags.lo_sat = depth_sample <= range_low_reg;
        in_flags.hi_sat = depth_sample >= range_high_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load[ST_IN])
        begin
            s0_flags_reg <= in_flags;
            s0_num_reg   <= depth_sample - range_low_reg;
        end
    end

    // ------------------------------------------------------------------
    // Depth divider: t = (num << 16) / span with num below span, one
    // quotient bit per stage. Saturated pixels pass through unused.
    // ------------------------------------------------------------------
    logic [DEPTH_BITS-1:0] da_rem_reg  [DIV_STEPS];
    logic [FRAC_BITS-1:0]  da_quo_reg  [DIV_STEPS];
    depth_flags_t          da_flags_reg[DIV_STEPS];
    logic [DEPTH_BITS-1:0] da_rem_src  [DIV_STEPS];
    logic [FRAC_BITS-1:0]  da_quo_src  [DIV_STEPS];
    depth_flags_t          da_flags_src[DIV_STEPS];
    logic [DEPTH_BITS:0]   da_trial    [DIV_STEPS];
    logic [DEPTH_BITS:0]   da_diff     [DIV_STEPS];
    logic                  da_fits     [DIV_STEPS];

    always_comb
    begin
        da_rem_src[0]   = s0_num_reg;
        da_quo_src[0]   = '0;
        da_flags_src[0] = s0_flags_reg;
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            da_rem_src[k]   = da_rem_reg[k-1];
            da_quo_src[k]   = da_quo_reg[k-1];
            da_flags_src[k] = da_flags_reg[k-1];
        end
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            da_trial[k] = {da_rem_src[k], 1'b0};
            da_fits[k]  = da_trial[k] >= {1'b0, span};
            da_diff[k]  = da_trial[k] - {1'b0, span};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if (load[ST_DA0 + k])
            begin
                da_rem_reg[k]   <= da_fits[k] ? da_diff[k][DEPTH_BITS-1:0]
                                              : da_trial[k][DEPTH_BITS-1:0];
                da_quo_reg[k]   <= {da_quo_src[k][FRAC_BITS-2:0], da_fits[k]};
                da_flags_reg[k] <= da_flags_src[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Near value: clamp t and invert so the near end is 1.0.
    // ------------------------------------------------------------------
    depth_flags_t      da_last;
    logic [UNIT_W-1:0] t_val;
    logic [UNIT_W-1:0] near_reg;
    logic              near_bg_reg;

    assign da_last = da_flags_reg[DIV_STEPS-1];

    always_comb
    begin
        if (da_last.lo_sat)
        begin
            t_val = '0;
        end
        else if (da_last.hi_sat)
        begin
            t_val = ONE_Q16;
        end
        else
        begin
            t_val = {1'b0, da_quo_reg[DIV_STEPS-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[ST_NEAR])
        begin
            near_reg    <= ONE_Q16 - t_val;
            near_bg_reg <= da_last.bg;
        end
    end

    // ------------------------------------------------------------------
    // Segment choice: the first segment whose upper edge lies above the
    // near value, else the last one. The blend position is x / w.
    // ------------------------------------------------------------------
    logic              seg_hit;
    logic [SEG_W-1:0]  seg_sel;
    logic [UNIT_W-1:0] seg_low;
    logic [UNIT_W-1:0] seg_top;
    logic [UNIT_W-1:0] seg_x;
    logic [UNIT_W-1:0] seg_w;
    seg_info_t         seg_info;
    seg_info_t         sg_info_reg;
    logic [UNIT_W-1:0] sg_x_reg;
    logic [UNIT_W-1:0] sg_w_reg;

    always_comb
    begin
        seg_hit = 1'b0;
        seg_sel = SEG_W'(PALETTE_SEGMENTS - 1);
        for (int i = 0; i < PALETTE_SEGMENTS; i++)
        begin
            if (!seg_hit && (near_reg < SEG_EDGE[i]))
            begin
                seg_hit = 1'b1;
                seg_sel = SEG_W'(i);
            end
        end
        seg_low = seg_lower(seg_sel);
        seg_top = SEG_EDGE[seg_sel];
        seg_x   = (near_reg > seg_low) ? (near_reg - seg_low) : '0;
        seg_w   = seg_top - seg_low;

        seg_info.bg    = near_bg_reg;
        seg_info.near  = near_reg;
        seg_info.seg   = seg_sel;
        // A segment with no width acts as a hard step.
        seg_info.degen = seg_top <= seg_low;
        // Only the top of the last segment reaches a full blend.
        seg_info.full  = seg_x >= seg_w;
    end

    always_ff @(posedge clk)
    begin
        if (load[ST_SEG])
        begin
            sg_info_reg <= seg_info;
            sg_x_reg    <= seg_x;
            sg_w_reg    <= seg_w;
        end
    end

    // ------------------------------------------------------------------
    // Blend divider: u = (x << 16) / w with x below w, one bit per stage.
    // ------------------------------------------------------------------
    logic [UNIT_W-1:0]    db_rem_reg [DIV_STEPS];
    logic [FRAC_BITS-1:0] db_quo_reg [DIV_STEPS];
    logic [UNIT_W-1:0]    db_w_reg   [DIV_STEPS];
    seg_info_t            db_info_reg[DIV_STEPS];
    logic [UNIT_W-1:0]    db_rem_src [DIV_STEPS];
    logic [FRAC_BITS-1:0] db_quo_src [DIV_STEPS];
    logic [UNIT_W-1:0]    db_w_src   [DIV_STEPS];
    seg_info_t            db_info_src[DIV_STEPS];
    logic [UNIT_W:0]      db_trial   [DIV_STEPS];
    logic [UNIT_W:0]      db_diff    [DIV_STEPS];
    logic                 db_fits    [DIV_STEPS];

    always_comb
    begin
        db_rem_src[0]  = sg_x_reg;
        db_quo_src[0]  = '0;
        db_w_src[0]    = sg_w_reg;
        db_info_src[0] = sg_info_reg;
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            db_rem_src[k]  = db_rem_reg[k-1];
            db_quo_src[k]  = db_quo_reg[k-1];
            db_w_src[k]    = db_w_reg[k-1];
            db_info_src[k] = db_info_reg[k-1];
        end
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            db_trial[k] = {db_rem_src[k], 1'b0};
            db_fits[k]  = db_trial[k] >= {1'b0, db_w_src[k]};
            db_diff[k]  = db_trial[k] - {1'b0, db_w_src[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if (load[ST_DB0 + k])
            begin
                db_rem_reg[k]  <= db_fits[k] ? db_diff[k][UNIT_W-1:0]
                                             : db_trial[k][UNIT_W-1:0];
                db_quo_reg[k]  <= {db_quo_src[k][FRAC_BITS-2:0], db_fits[k]};
                db_w_reg[k]    <= db_w_src[k];
                db_info_reg[k] <= db_info_src[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Smoothstep: u, then u^2, then s = u^2 * (3 - 2u).
    // ------------------------------------------------------------------
    seg_info_t                db_last;
    logic [UNIT_W-1:0]        u_reg;
    seg_info_t                u_info_reg;
    logic [2*UNIT_W-1:0]      u_sq;
    logic [UNIT_W-1:0]        u2_reg;
    logic [UNIT_W-1:0]        u2_u_reg;
    seg_info_t                u2_info_reg;
    logic [UNIT_W:0]          s_weight;
    logic [2*UNIT_W:0]        s_prod;
    logic [UNIT_W-1:0]        s_reg;
    seg_info_t                s_info_reg;

    assign db_last  = db_info_reg[DIV_STEPS-1];
    assign u_sq     = u_reg * u_reg;
    assign s_weight = SMOOTH_K - {u2_u_reg, 1'b0};
    assign s_prod   = u2_reg * s_weight;

    always_ff @(posedge clk)
    begin
        if (load[ST_U])
        begin
            u_reg      <= db_last.full ? ONE_Q16 : {1'b0, db_quo_reg[DIV_STEPS-1]};
            u_info_reg <= db_last;
        end
        if (load[ST_U2])
        begin
            u2_reg      <= u_sq[FRAC_BITS +: UNIT_W];
            u2_u_reg    <= u_reg;
            u2_info_reg <= u_info_reg;
        end
        if (load[ST_S])
        begin
            s_reg      <= u2_info_reg.degen ? ONE_Q16 : s_prod[FRAC_BITS +: UNIT_W];
            s_info_reg <= u2_info_reg;
        end
    end

    // ------------------------------------------------------------------
    // Colour blend, written as from + (to - from) * s so each channel
    // needs one multiplier.
    // ------------------------------------------------------------------
    logic [COL_IDX_W-1:0]        p_from_idx;
    logic [COL_IDX_W-1:0]        p_to_idx;
    logic signed [FRAC_BITS:0]   p_delta[3];
    logic signed [P_W-1:0]       p_prod [3];
    logic signed [P_W-1:0]       p_reg  [3];
    seg_info_t                   p_info_reg;
    logic [COL_IDX_W-1:0]        v_from_idx;
    logic signed [MIX_W-1:0]     v_sum  [3];
    logic [UNIT_W-1:0]           v_next [3];
    logic [UNIT_W-1:0]           v_reg  [3];
    logic                        v_bg_reg;

    assign p_from_idx = COL_IDX_W'(s_info_reg.seg);
    assign p_to_idx   = COL_IDX_W'(s_info_reg.seg) + COL_IDX_W'(1);
    assign v_from_idx = COL_IDX_W'(p_info_reg.seg);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            p_delta[c] = $signed({1'b0, PAL_COLOR[p_to_idx][c]}) -
                         $signed({1'b0, PAL_COLOR[p_from_idx][c]});
            p_prod[c]  = p_delta[c] * $signed({1'b0, s_reg});

            v_sum[c]   = $signed(MIX_W'({PAL_COLOR[v_from_idx][c], {FRAC_BITS{1'b0}}})) +
                         MIX_W'(p_reg[c]) + MIX_ROUND;
            // Grayscale mode puts the near value on every channel.
            v_next[c]  = color_mode_reg ? p_info_reg.near
                                        : v_sum[c][FRAC_BITS +: UNIT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[ST_P])
        begin
            for (int c = 0; c < 3; c++)
            begin
                p_reg[c] <= p_prod[c];
            end
            p_info_reg <= s_info_reg;
        end
        if (load[ST_V])
        begin
            for (int c = 0; c < 3; c++)
            begin
                v_reg[c] <= v_next[c];
            end
            v_bg_reg <= p_info_reg.bg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: scale Q0.16 to the channel code with rounding, so
    // 1.0 maps to the largest code, or substitute the background colour.
    // ------------------------------------------------------------------
    logic [UNIT_W+COLOR_BITS:0] ch_scaled[3];
    logic [COLOR_BITS-1:0]      out_red_reg;
    logic [COLOR_BITS-1:0]      out_green_reg;
    logic [COLOR_BITS-1:0]      out_blue_reg;
    logic                       out_bg_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ch_scaled[c] = (UNIT_W + COLOR_BITS + 1)'(v_reg[c]) * COLOR_MAX + CH_ROUND;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[ST_OUT])
        begin
            out_bg_reg    <= v_bg_reg;
            out_red_reg   <= v_bg_reg ? bg_red_reg   : ch_scaled[0][FRAC_BITS +: COLOR_BITS];
            out_green_reg <= v_bg_reg ? bg_green_reg : ch_scaled[1][FRAC_BITS +: COLOR_BITS];
            out_blue_reg  <= v_bg_reg ? bg_blue_reg  : ch_scaled[2][FRAC_BITS +: COLOR_BITS];
        end
    end

    assign color_valid   = vld_reg[ST_OUT];
    assign red           = out_red_reg;
    assign green         = out_green_reg;
    assign blue          = out_blue_reg;
    assign is_background = out_bg_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A background result carries exactly the configured background colour.
    a_bg_color: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && is_background |->
            red == bg_red_reg && green == bg_green_reg && blue == bg_blue_reg)
        else $error("background result does not match background registers");

    // Grayscale results are gray.
    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && !is_background && color_mode_reg |->
            red == green && green == blue)
        else $error("grayscale result has unequal channels");

    // The input is held off only when every stage is full and the output waits.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        depth_stall |-> (&vld_reg) && color_stall)
        else $error("input stalled while the pipeline has room");

    // The smoothstep weight never exceeds 1.0.
    a_smooth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_S] |-> s_reg <= ONE_Q16)
        else $error("smoothstep weight above one");

endmodule
